[hdl/chd_pkg.sv]
// Package for the canonical Huffman decoder: sizes, opcodes, state codes,
// the word structs of both channels and the controller/datapath structs.
// Depends on nothing; every other file of the block but chd_ram uses it.
`default_nettype none

package chd_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_SYMBOLS  = 256;
    localparam int SYM_AW       = $clog2(NUM_SYMBOLS);

    localparam int LC_DEPTH = 32;
    localparam int LC_AW    = 5;
    localparam int CNT_W    = 9;
    localparam int CODE_W   = 33;
    localparam int PL_W     = 6;
    localparam int BASE_W   = 9;
    localparam int POS_W    = BASE_W + 1;
    localparam int OLEN_W   = 56;
    localparam int BIT_W    = 3;

    localparam int APB_AW = 3;
    localparam int APB_DW = 64;
    localparam logic [APB_AW-1:0] REG_OUTPUT_LENGTH = 3'd0;

    typedef enum logic [1:0] {
        OP_LOAD_LEN = 2'd0,
        OP_LOAD_SYM = 2'd1,
        OP_DECODE   = 2'd2,
        OP_RESTART  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_BIT   = 2'd1,
        S_PUSH  = 2'd2,
        S_FLUSH = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] entry_index;
        logic [8:0] load_value;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       last_of_run;
        logic       stream_done;
    } t_out;

    typedef struct packed {
        logic load_len;
        logic load_sym;
        logic restart;
        logic start;
        logic step;
        logic pend_load;
        logic pend_clear;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic stop;
        logic result;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[hdl/chd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/chd_ctrl.sv]
// Sequencer of the decoder: accepts words, steps the bit loop and moves
// results to the output. Depends on chd_pkg.
`default_nettype none

module chd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_opcode,
    input  wire chd_pkg::t_sts i_sts,
    output logic               o_in_stall,
    output chd_pkg::t_cmd      o_cmd
);

    chd_pkg::t_state r_state;
    chd_pkg::t_state n_state;
    chd_pkg::t_op    op;

    assign op = chd_pkg::t_op'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            chd_pkg::S_IDLE: begin
                if (i_in_valid && op == chd_pkg::OP_DECODE) begin
                    n_state = chd_pkg::S_BIT;
                end
            end
            chd_pkg::S_BIT: begin
                if (i_sts.stop) begin
                    n_state = chd_pkg::S_FLUSH;
                end else if (i_sts.result) begin
                    n_state = chd_pkg::S_PUSH;
                end
            end
            chd_pkg::S_PUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    n_state = chd_pkg::S_BIT;
                end
            end
            chd_pkg::S_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    n_state = chd_pkg::S_IDLE;
                end
            end
            default: n_state = chd_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            chd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (op)
                        chd_pkg::OP_LOAD_LEN: o_cmd.load_len = 1'b1;
                        chd_pkg::OP_LOAD_SYM: o_cmd.load_sym = 1'b1;
                        chd_pkg::OP_DECODE:   o_cmd.start    = 1'b1;
                        chd_pkg::OP_RESTART:  o_cmd.restart  = 1'b1;
                        default:              o_cmd.start    = 1'b0;
                    endcase
                end
            end
            chd_pkg::S_BIT: begin
                o_cmd.step = !i_sts.stop;
            end
            chd_pkg::S_PUSH: begin
                if (!i_sts.pend_valid) begin
                    o_cmd.pend_load = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.out_load  = 1'b1;
                end
            end
            chd_pkg::S_FLUSH: begin
                if (i_sts.pend_valid && i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.pend_clear = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != chd_pkg::S_IDLE);

endmodule

`default_nettype wire

[hdl/chd_dp.sv]
// Datapath of the decoder: code book, code accumulator, bit matcher and the
// pending and output result registers. Depends on chd_pkg and chd_ram.
`default_nettype none

module chd_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire chd_pkg::t_cmd               i_cmd,
    input  wire chd_pkg::t_in                i_in_data,
    input  wire logic [chd_pkg::OLEN_W-1:0]  i_output_length,
    input  wire logic                        i_out_stall,
    output chd_pkg::t_sts                    o_sts,
    output chd_pkg::t_out                    o_out_data,
    output logic                             o_out_valid
);

    localparam int CW = chd_pkg::CODE_W;

    logic [chd_pkg::CNT_W-1:0]  r_lc [chd_pkg::LC_DEPTH];
    logic [CW-1:0]              r_pc, n_pc;
    logic [chd_pkg::PL_W-1:0]   r_pl, n_pl;
    logic [CW-1:0]              r_fc, n_fc;
    logic [chd_pkg::BASE_W-1:0] r_base, n_base;
    logic [chd_pkg::OLEN_W-1:0] r_prod, n_prod;
    logic                       r_fin, n_fin;
    logic [7:0]                 r_byte;
    logic [chd_pkg::BIT_W-1:0]  r_bit;
    logic                       r_byte_end;
    logic                       r_fr_err, r_fr_done, r_fr_inr;
    chd_pkg::t_out              r_pd;
    logic                       r_pd_valid;
    chd_pkg::t_out              r_out;
    logic                       r_out_valid;

    logic                       cur_bit;
    logic [CW-1:0]              pc_s;
    logic [chd_pkg::PL_W-1:0]   pl_inc;
    logic [chd_pkg::CNT_W-1:0]  cnt;
    logic [CW:0]                diff;
    logic                       match;
    logic                       overlong;
    logic [chd_pkg::POS_W-1:0]  pos;
    logic                       inr;
    logic [chd_pkg::OLEN_W-1:0] prod_inc;
    logic                       done;
    logic [chd_pkg::POS_W-1:0]  nb;
    logic [CW:0]                nf;
    logic [CW-1:0]              fc_adv;
    logic [7:0]                 ram_rdata;
    logic [7:0]                 fresh_sym;
    logic                       sym_we;
    logic                       out_free;

    // One bit of the current byte against the running first code.
    assign cur_bit  = r_byte[r_bit];
    assign pc_s     = {r_pc[CW-2:0], cur_bit};
    assign pl_inc   = r_pl + 1'b1;
    assign cnt      = r_lc[r_pl[chd_pkg::LC_AW-1:0]];
    assign diff     = {1'b0, pc_s} - {1'b0, r_fc};
    assign match    = !diff[CW] && (diff[CW-1:0] < CW'(cnt));
    assign overlong = !match && (pl_inc >= chd_pkg::PL_W'(chd_pkg::MAX_CODE_LEN));
    assign pos      = chd_pkg::POS_W'(r_base) + chd_pkg::POS_W'(diff[chd_pkg::CNT_W-1:0]);
    assign inr      = pos < chd_pkg::POS_W'(chd_pkg::NUM_SYMBOLS);
    assign prod_inc = r_prod + 1'b1;
    assign done     = (prod_inc == i_output_length);
    assign nb       = chd_pkg::POS_W'(r_base) + chd_pkg::POS_W'(cnt);
    assign nf       = {1'b0, r_fc} + (CW + 1)'(cnt);
    assign fc_adv   = (nf[CW:CW-1] != 2'b00) ? '1 : {nf[CW-2:0], 1'b0};

    always_comb begin
        n_pc   = r_pc;
        n_pl   = r_pl;
        n_fc   = r_fc;
        n_base = r_base;
        n_prod = r_prod;
        n_fin  = r_fin;
        if (i_cmd.restart) begin
            n_pc   = '0;
            n_pl   = '0;
            n_fc   = '0;
            n_base = '0;
            n_prod = '0;
            n_fin  = 1'b0;
        end else if (i_cmd.step) begin
            if (match || overlong) begin
                n_pc   = '0;
                n_pl   = '0;
                n_fc   = '0;
                n_base = '0;
            end else begin
                n_pc   = pc_s;
                n_pl   = pl_inc;
                n_fc   = fc_adv;
                n_base = nb[chd_pkg::BASE_W] ? '1 : nb[chd_pkg::BASE_W-1:0];
            end
            if (match) begin
                n_prod = prod_inc;
                n_fin  = done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < chd_pkg::LC_DEPTH; i++) begin
                r_lc[i] <= '0;
            end
            r_pc        <= '0;
            r_pl        <= '0;
            r_fc        <= '0;
            r_base      <= '0;
            r_prod      <= '0;
            r_fin       <= 1'b0;
            r_byte_end  <= 1'b1;
            r_pd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_len && i_in_data.entry_index[7:chd_pkg::LC_AW] == '0) begin
                r_lc[i_in_data.entry_index[chd_pkg::LC_AW-1:0]] <= i_in_data.load_value;
            end
            r_pc   <= n_pc;
            r_pl   <= n_pl;
            r_fc   <= n_fc;
            r_base <= n_base;
            r_prod <= n_prod;
            r_fin  <= n_fin;
            if (i_cmd.start) begin
                r_byte_end <= 1'b0;
            end else if (i_cmd.step) begin
                r_byte_end <= (r_bit == '0);
            end
            if (i_cmd.pend_load) begin
                r_pd_valid <= 1'b1;
            end else if (i_cmd.pend_clear) begin
                r_pd_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_byte <= i_in_data.data_byte;
            r_bit  <= '1;
        end else if (i_cmd.step) begin
            r_bit  <= r_bit - 1'b1;
        end
        if (i_cmd.step) begin
            r_fr_err  <= !match;
            r_fr_done <= match && done;
            r_fr_inr  <= inr;
        end
        if (i_cmd.pend_load) begin
            r_pd.symbol      <= fresh_sym;
            r_pd.status      <= r_fr_err;
            r_pd.last_of_run <= 1'b0;
            r_pd.stream_done <= r_fr_done;
        end
        if (i_cmd.out_load) begin
            r_out <= '{symbol:      r_pd.symbol,
                       status:      r_pd.status,
                       last_of_run: i_cmd.out_last,
                       stream_done: r_pd.stream_done};
        end
    end

    assign sym_we = i_cmd.load_sym
                 && ({1'b0, i_in_data.entry_index} < 9'(chd_pkg::NUM_SYMBOLS));

    chd_ram #(
        .WIDTH (8),
        .DEPTH (chd_pkg::NUM_SYMBOLS)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (i_in_data.entry_index[chd_pkg::SYM_AW-1:0]),
        .i_wdata (i_in_data.load_value[7:0]),
        .i_re    (i_cmd.step && match && inr),
        .i_raddr (pos[chd_pkg::SYM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign fresh_sym = (r_fr_err || !r_fr_inr) ? 8'h00 : ram_rdata;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_sts.stop       = r_byte_end || r_fin;
    assign o_sts.result     = match || overlong;
    assign o_sts.pend_valid = r_pd_valid;
    assign o_sts.out_free   = out_free;

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hdl/canonical_huffman_decoder.sv]
// Top level of the canonical Huffman decoder: channel ports, the APB
// register for the output length, the sequencer and the datapath.
// Depends on chd_pkg, chd_ctrl, chd_dp (and through it chd_ram).
`default_nettype none

// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+--------------------------
// input     | in        | i_in_valid / o_in_stall | chd_pkg::t_in  i_in_data
// output    | out       | o_out_valid / i_out_stall | chd_pkg::t_out o_out_data
// config    | in        | psel/penable/pwrite/pready | output_length, 7-byte reg
//
// Load and restart words are taken in the idle state. A decode word is
// accepted in the idle state, then each bit goes through the single
// first-code compare unit, each result through a push step (registered
// symbol RAM read), then one end-of-byte step and one flush step.
// Reset is synchronous and clears the length counts in flip-flops at once;
// the symbol RAM has no clearing pass. Output stalls hold the block in the
// push or flush step until the output register frees up.

module canonical_huffman_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire chd_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output chd_pkg::t_out                    o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [chd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [chd_pkg::APB_DW-1:0]  pwdata,
    output logic      [chd_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);

    logic [chd_pkg::OLEN_W-1:0] r_output_length;
    chd_pkg::t_cmd              cmd;
    chd_pkg::t_sts              sts;

    // The user must write the output length register only while the decoder is
    // idle (the block does not enforce it), so the datapath reads it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_length <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == chd_pkg::REG_OUTPUT_LENGTH) begin
            r_output_length <= pwdata[chd_pkg::OLEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == chd_pkg::REG_OUTPUT_LENGTH)
                  ? chd_pkg::APB_DW'(r_output_length) : '0;

    chd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    chd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_in_data       (i_in_data),
        .i_output_length (r_output_length),
        .i_out_stall     (i_out_stall),
        .o_sts           (sts),
        .o_out_data      (o_out_data),
        .o_out_valid     (o_out_valid)
    );

endmodule

`default_nettype wire
